@@ rtl/asse_pkg.sv @@
// Shared types and codes of the atomic semaphore set engine.
// Holds the beat payload structs and the controller/datapath command and status structs.
// No dependencies.
package asse_pkg;

   localparam logic [1:0] ACT_OP       = 2'd0;
   localparam logic [1:0] ACT_SET      = 2'd1;
   localparam logic [1:0] ACT_READ_VAL = 2'd2;
   localparam logic [1:0] ACT_READ_REQ = 2'd3;

   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_WAIT      = 3'd1;
   localparam logic [2:0] ST_TRY_AGAIN = 3'd2;
   localparam logic [2:0] ST_RANGE     = 3'd3;
   localparam logic [2:0] ST_BAD_INDEX = 3'd4;
   localparam logic [2:0] ST_TOO_MANY  = 3'd5;
   localparam logic [2:0] ST_BAD_VALUE = 3'd6;

   localparam logic [1:0] CSR_SEM_COUNT    = 2'd0;
   localparam logic [1:0] CSR_VALUE_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_ADJUST_LIMIT = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         sem_index;
      logic signed [15:0] delta;
      logic [15:0]        new_value;
      logic               undo_flag;
      logic               no_wait;
      logic [2:0]         requester;
      logic               last_op;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       buf_op;
      logic       rd_issue;
      logic       set_write;
      logic       uclr_step;
      logic       wipe_step;
      logic       commit_start;
      logic       op_read;
      logic       op_fetch;
      logic       op_eval;
      logic       op_copy_fetch;
      logic       op_copy_write;
      logic       next_op;
      logic       op_rewind;
      logic       res_we;
      logic [2:0] res_code;
      logic       res_rv;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       last_op;
      logic       idx_ok;
      logic       nval_bad;
      logic       too_many;
      logic       bad_index;
      logic       fail;
      logic [2:0] fail_code;
      logic       op_last;
      logic       uclr_last;
      logic       wipe_last;
      logic       rsp_room;
   } stat_type;

endpackage

@@ rtl/asse_ram.sv @@
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module asse_ram #(
   parameter int W = 16,
   parameter int D = 64
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [(D > 1 ? $clog2(D) : 1)-1:0] wr_addr,
   input  logic [W-1:0]                        wr_data,
   input  logic                                rd_en,
   input  logic [(D > 1 ? $clog2(D) : 1)-1:0] rd_addr,
   output logic [W-1:0]                        rd_data
);
   logic [W-1:0] mem [D];
   logic [W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/asse_ctrl.sv @@
// Sequencing state machine of the semaphore set engine.
// Depends on asse_pkg for the command and status structs and the codes.
module asse_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  asse_pkg::stat_type st,
   output asse_pkg::cmd_type  cmd
);
   import asse_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_WIPE     = 4'd1;
   localparam logic [3:0] S_DECODE   = 4'd2;
   localparam logic [3:0] S_READ     = 4'd3;
   localparam logic [3:0] S_SETCLR   = 4'd4;
   localparam logic [3:0] S_P1_RD    = 4'd5;
   localparam logic [3:0] S_P1_FETCH = 4'd6;
   localparam logic [3:0] S_P1_EVAL  = 4'd7;
   localparam logic [3:0] S_P2_RD    = 4'd8;
   localparam logic [3:0] S_P2_FETCH = 4'd9;
   localparam logic [3:0] S_P2_WR    = 4'd10;
   localparam logic [3:0] S_RESP     = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_WIPE: begin
            cmd.wipe_step = 1'b1;
            if (st.wipe_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (st.action == ACT_OP) begin
               cmd.buf_op = 1'b1;
               if (!st.last_op) begin
                  state_in = S_IDLE;
               end else if (st.too_many) begin
                  cmd.res_we = 1'b1;
                  cmd.res_code = ST_TOO_MANY;
                  state_in = S_RESP;
               end else if (st.bad_index) begin
                  cmd.res_we = 1'b1;
                  cmd.res_code = ST_BAD_INDEX;
                  state_in = S_RESP;
               end else begin
                  cmd.commit_start = 1'b1;
                  state_in = S_P1_RD;
               end
            end else if (!st.idx_ok) begin
               cmd.res_we = 1'b1;
               cmd.res_code = ST_BAD_INDEX;
               state_in = S_RESP;
            end else if (st.action == ACT_SET) begin
               if (st.nval_bad) begin
                  cmd.res_we = 1'b1;
                  cmd.res_code = ST_BAD_VALUE;
                  state_in = S_RESP;
               end else begin
                  cmd.set_write = 1'b1;
                  state_in = S_SETCLR;
               end
            end else begin
               cmd.rd_issue = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.res_we = 1'b1;
            cmd.res_code = ST_DONE;
            cmd.res_rv = 1'b1;
            state_in = S_RESP;
         end
         S_SETCLR: begin
            cmd.uclr_step = 1'b1;
            if (st.uclr_last) begin
               cmd.res_we = 1'b1;
               cmd.res_code = ST_DONE;
               state_in = S_RESP;
            end
         end
         S_P1_RD: begin
            cmd.op_read = 1'b1;
            state_in = S_P1_FETCH;
         end
         S_P1_FETCH: begin
            cmd.op_fetch = 1'b1;
            state_in = S_P1_EVAL;
         end
         S_P1_EVAL: begin
            cmd.op_eval = 1'b1;
            if (st.fail) begin
               cmd.res_we = 1'b1;
               cmd.res_code = st.fail_code;
               state_in = S_RESP;
            end else if (st.op_last) begin
               cmd.op_rewind = 1'b1;
               state_in = S_P2_RD;
            end else begin
               cmd.next_op = 1'b1;
               state_in = S_P1_RD;
            end
         end
         S_P2_RD: begin
            cmd.op_read = 1'b1;
            state_in = S_P2_FETCH;
         end
         S_P2_FETCH: begin
            cmd.op_copy_fetch = 1'b1;
            state_in = S_P2_WR;
         end
         S_P2_WR: begin
            cmd.op_copy_write = 1'b1;
            if (st.op_last) begin
               cmd.res_we = 1'b1;
               cmd.res_code = ST_DONE;
               state_in = S_RESP;
            end else begin
               cmd.next_op = 1'b1;
               state_in = S_P2_RD;
            end
         end
         S_RESP: begin
            if (st.rsp_room) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> st.rsp_room)
      else $error("Result loaded while the output register is occupied.");

   a_fail_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_P1_EVAL && st.fail) |=> state_ff == S_RESP)
      else $error("A failed check did not end the commit.");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> state_ff == S_DECODE)
      else $error("An accepted beat was not decoded.");

endmodule

@@ rtl/asse_dp.sv @@
// Datapath of the semaphore set engine: stores, op buffer, shadow copies and checks.
// Depends on asse_pkg and asse_ram.
module asse_dp #(
   parameter int NSEMS   = 64,
   parameter int MAX_OPS = 32,
   parameter int NPROC   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  asse_pkg::cmd_type  cmd,
   output asse_pkg::stat_type st,
   input  asse_pkg::req_type  req_data,
   input  logic [6:0]         sem_count,
   input  logic [14:0]        value_limit,
   input  logic [14:0]        adjust_limit,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output asse_pkg::rsp_type  rsp_data
);
   import asse_pkg::*;

   localparam int SW = NSEMS > 1 ? $clog2(NSEMS) : 1;
   localparam int PW = NPROC > 1 ? $clog2(NPROC) : 1;
   localparam int UD = NSEMS * NPROC;
   localparam int UW = UD > 1 ? $clog2(UD) : 1;
   localparam int OW = MAX_OPS > 1 ? $clog2(MAX_OPS) : 1;
   localparam int FW = $clog2(MAX_OPS + 1);
   localparam int EW = SW + 18;

   function automatic logic [PW-1:0] slot_of(input logic [2:0] r);
      logic [3:0] v;
      v = {1'b0, r};
      for (int j = 0; j < 8; j++) begin
         if (v >= 4'(NPROC)) begin
            v = v - 4'(NPROC);
         end
      end
      return PW'(v);
   endfunction

   req_type           req_ff;
   logic [FW-1:0]     fill_ff;
   logic [1:0]        err_ff;
   logic [FW-1:0]     n_ff;
   logic [OW-1:0]     i_ff;
   logic [PW-1:0]     p_ff;
   logic [UW-1:0]     wipe_ff;
   logic [UW-1:0]     slot_base_ff;
   logic [NSEMS-1:0]  vld_ff;
   logic [NSEMS-1:0]  touched_ff;
   logic [2:0]        res_status_ff;
   logic [15:0]       res_value_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic [SW-1:0]     kq;
   logic [SW-1:0]     kop;
   logic [EW-1:0]     op_dout;
   logic signed [15:0] op_delta;
   logic              op_undo;
   logic              op_nowait;
   logic [14:0]       sem_dout;
   logic [2:0]        lreq_dout;
   logic [15:0]       undo_dout;
   logic [14:0]       shv_dout;
   logic [15:0]       sha_dout;

   logic              buf_full;
   logic [14:0]       cur;
   logic signed [16:0] res;
   logic [15:0]       adj_cur;
   logic signed [17:0] adj_new;
   logic signed [17:0] adj_lo;
   logic signed [17:0] adj_hi;
   logic              blocked;
   logic              over;
   logic              adj_bad;

   logic              sem_we;
   logic [SW-1:0]     sem_waddr;
   logic [14:0]       sem_wdata;
   logic [SW-1:0]     sem_raddr;
   logic              undo_we;
   logic [UW-1:0]     undo_waddr;
   logic [15:0]       undo_wdata;

   assign kq = req_ff.sem_index[SW-1:0];
   assign kop = op_dout[EW-1:18];
   assign op_delta = op_dout[17:2];
   assign op_undo = op_dout[1];
   assign op_nowait = op_dout[0];
   assign buf_full = (fill_ff >= FW'(MAX_OPS));

   assign cur = touched_ff[kop] ? shv_dout : (vld_ff[kop] ? sem_dout : 15'd0);
   assign res = $signed({2'b00, cur}) + 17'(op_delta);
   assign blocked = (op_delta == 16'sd0 && cur != 15'd0) || res < 17'sd0;
   assign over = res > $signed({2'b00, value_limit});
   assign adj_cur = touched_ff[kop] ? sha_dout : undo_dout;
   assign adj_new = 18'(signed'(adj_cur)) - 18'(op_delta);
   assign adj_hi = $signed({3'b000, adjust_limit});
   assign adj_lo = -adj_hi - 18'sd1;
   assign adj_bad = op_undo && (adj_new < adj_lo || adj_new > adj_hi);

   always_comb begin
      st = '0;
      st.action = req_ff.action;
      st.last_op = req_ff.last_op;
      st.idx_ok = ({1'b0, req_ff.sem_index} < {2'b00, sem_count})
                  && ({1'b0, req_ff.sem_index} < 9'(NSEMS));
      st.nval_bad = req_ff.new_value > {1'b0, value_limit};
      st.too_many = err_ff[1] | buf_full;
      st.bad_index = err_ff[0] | (!buf_full && !st.idx_ok);
      st.fail = blocked | over | adj_bad;
      st.fail_code = blocked ? (op_nowait ? ST_TRY_AGAIN : ST_WAIT) : ST_RANGE;
      st.op_last = (FW'(i_ff) + FW'(1)) == n_ff;
      st.uclr_last = (p_ff == PW'(NPROC - 1));
      st.wipe_last = (wipe_ff == UW'(UD - 1));
      st.rsp_room = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      sem_we = cmd.set_write | cmd.op_copy_write;
      sem_waddr = cmd.set_write ? kq : kop;
      sem_wdata = cmd.set_write ? req_ff.new_value[14:0] : shv_dout;
      sem_raddr = cmd.rd_issue ? kq : kop;
      undo_we = cmd.wipe_step | cmd.uclr_step | cmd.op_copy_write;
      undo_wdata = cmd.op_copy_write ? sha_dout : 16'd0;
      if (cmd.wipe_step) begin
         undo_waddr = wipe_ff;
      end else if (cmd.uclr_step) begin
         undo_waddr = UW'(UW'(p_ff) * UW'(NSEMS)) + UW'(kq);
      end else begin
         undo_waddr = slot_base_ff + UW'(kop);
      end
   end

   asse_ram #(.W(EW), .D(MAX_OPS)) u_opbuf (
      .clock(clock),
      .wr_en(cmd.buf_op && !buf_full),
      .wr_addr(OW'(fill_ff)),
      .wr_data({kq, req_ff.delta, req_ff.undo_flag, req_ff.no_wait}),
      .rd_en(cmd.op_read),
      .rd_addr(i_ff),
      .rd_data(op_dout)
   );

   asse_ram #(.W(15), .D(NSEMS)) u_sem (
      .clock(clock),
      .wr_en(sem_we),
      .wr_addr(sem_waddr),
      .wr_data(sem_wdata),
      .rd_en(cmd.rd_issue | cmd.op_fetch),
      .rd_addr(sem_raddr),
      .rd_data(sem_dout)
   );

   asse_ram #(.W(3), .D(NSEMS)) u_lreq (
      .clock(clock),
      .wr_en(sem_we),
      .wr_addr(sem_waddr),
      .wr_data(req_ff.requester),
      .rd_en(cmd.rd_issue),
      .rd_addr(kq),
      .rd_data(lreq_dout)
   );

   asse_ram #(.W(16), .D(UD)) u_undo (
      .clock(clock),
      .wr_en(undo_we),
      .wr_addr(undo_waddr),
      .wr_data(undo_wdata),
      .rd_en(cmd.op_fetch),
      .rd_addr(slot_base_ff + UW'(kop)),
      .rd_data(undo_dout)
   );

   asse_ram #(.W(15), .D(NSEMS)) u_shadow_val (
      .clock(clock),
      .wr_en(cmd.op_eval && !st.fail),
      .wr_addr(kop),
      .wr_data(res[14:0]),
      .rd_en(cmd.op_fetch | cmd.op_copy_fetch),
      .rd_addr(kop),
      .rd_data(shv_dout)
   );

   asse_ram #(.W(16), .D(NSEMS)) u_shadow_adj (
      .clock(clock),
      .wr_en(cmd.op_eval && !st.fail),
      .wr_addr(kop),
      .wr_data(op_undo ? adj_new[15:0] : adj_cur),
      .rd_en(cmd.op_fetch | cmd.op_copy_fetch),
      .rd_addr(kop),
      .rd_data(sha_dout)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.commit_start) begin
         slot_base_ff <= UW'(UW'(slot_of(req_ff.requester)) * UW'(NSEMS));
      end
      if (cmd.res_we) begin
         res_status_ff <= cmd.res_code;
         if (!cmd.res_rv) begin
            res_value_ff <= 16'd0;
         end else if (req_ff.action == ACT_READ_VAL) begin
            res_value_ff <= {1'b0, vld_ff[kq] ? sem_dout : 15'd0};
         end else begin
            res_value_ff <= {13'd0, vld_ff[kq] ? lreq_dout : 3'd0};
         end
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= '{status: res_status_ff, read_value: res_value_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         err_ff <= '0;
         n_ff <= '0;
         i_ff <= '0;
         p_ff <= '0;
         wipe_ff <= '0;
         vld_ff <= '0;
         touched_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.wipe_step) begin
            wipe_ff <= wipe_ff + UW'(1);
         end
         if (cmd.buf_op) begin
            if (req_ff.last_op) begin
               fill_ff <= '0;
               err_ff <= '0;
               n_ff <= fill_ff + FW'(1);
            end else if (buf_full) begin
               err_ff[1] <= 1'b1;
            end else begin
               err_ff[0] <= err_ff[0] | !st.idx_ok;
               fill_ff <= fill_ff + FW'(1);
            end
         end
         if (cmd.commit_start) begin
            touched_ff <= '0;
            i_ff <= '0;
         end
         if (cmd.op_rewind) begin
            i_ff <= '0;
         end else if (cmd.next_op) begin
            i_ff <= i_ff + OW'(1);
         end
         if (cmd.op_eval && !st.fail) begin
            touched_ff[kop] <= 1'b1;
         end
         if (cmd.set_write) begin
            p_ff <= '0;
         end else if (cmd.uclr_step) begin
            p_ff <= p_ff + PW'(1);
         end
         if (sem_we) begin
            vld_ff[sem_waddr] <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
endmodule

@@ rtl/atomic_semaphore_set_engine_core.sv @@
// Top level of the atomic semaphore set engine: configuration registers and the
// controller and datapath. Depends on asse_pkg, asse_ctrl, asse_dp and asse_ram.
//
// After reset the undo store is swept to zero, one entry a cycle, over all NSEMS*NPROC
// entries, and no beat is taken until that sweep ends. An op element that is not the
// last of its set is captured and then written into the op buffer. A set value clears
// one undo entry per requester slot in turn. The last op element of a set runs a
// checking pass over its elements (op buffer read, store read, check and shadow write)
// and then a copy pass over its elements (op buffer read, shadow read, write into the
// semaphore and undo stores); a failing check ends the set at once. A finished result
// waits in the output register while the next beat is taken.
module atomic_semaphore_set_engine_core #(
   parameter int NSEMS   = 64,
   parameter int MAX_OPS = 32,
   parameter int NPROC   = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  asse_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output asse_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [14:0]       csr_wdata
);
   import asse_pkg::*;

   logic [6:0]  sem_count_ff;
   logic [14:0] value_limit_ff;
   logic [14:0] adjust_limit_ff;
   logic        req_ready;
   cmd_type     cmd;
   stat_type    st;

   assign csr_ready = 1'b1;
   assign req_stall = !req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sem_count_ff <= 7'd64;
         value_limit_ff <= 15'd32767;
         adjust_limit_ff <= 15'd16384;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SEM_COUNT:    sem_count_ff <= csr_wdata[6:0];
            CSR_VALUE_LIMIT:  value_limit_ff <= csr_wdata;
            CSR_ADJUST_LIMIT: adjust_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   asse_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .st(st),
      .cmd(cmd)
   );

   asse_dp #(.NSEMS(NSEMS), .MAX_OPS(MAX_OPS), .NPROC(NPROC)) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .st(st),
      .req_data(req_data),
      .sem_count(sem_count_ff),
      .value_limit(value_limit_ff),
      .adjust_limit(adjust_limit_ff),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );
endmodule
